// File: hdl/usn_pkg.sv
// ----------------------------------------------------------------------------
// usn_pkg
// Shared widths and types for the surface normal pipeline.
// ----------------------------------------------------------------------------
package usn_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 14;

    // Cross product component, its magnitude, the root and the squared sum.
    localparam int CROSS_W = 2 * COORD_WIDTH + 1;
    localparam int MAG_W   = 2 * COORD_WIDTH;
    localparam int ROOT_W  = MAG_W;
    localparam int SUM_W   = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 2;
    localparam int DIV_W   = ROOT_W + 1;
    localparam int QUO_W   = FRAC_BITS + 1;

    // Fixed output field widths.
    localparam int NORM_W  = 16;
    localparam int LEN_W   = 32;

    // Cross product as sign and magnitude per component.
    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
    } usn_vec_t;

endpackage

// File: hdl/usn_cross.sv
// ----------------------------------------------------------------------------
// usn_cross
// Cross product, component magnitudes, squares and their sum in four stages.
// ----------------------------------------------------------------------------
module usn_cross
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  logic                                    in_valid,
    input  logic signed [usn_pkg::COORD_WIDTH-1:0]  ax,
    input  logic signed [usn_pkg::COORD_WIDTH-1:0]  ay,
    input  logic signed [usn_pkg::COORD_WIDTH-1:0]  az,
    input  logic signed [usn_pkg::COORD_WIDTH-1:0]  bx,
    input  logic signed [usn_pkg::COORD_WIDTH-1:0]  by,
    input  logic signed [usn_pkg::COORD_WIDTH-1:0]  bz,
    output logic                                    out_valid,
    output usn_pkg::usn_vec_t                       vec,
    output logic [usn_pkg::SUM_W-1:0]               sum
);

    localparam int PW = 2 * usn_pkg::COORD_WIDTH;

    logic [3:0] vld_reg;

    logic signed [PW-1:0] p_reg [6];
    logic signed [usn_pkg::CROSS_W-1:0] c_next [3];
    usn_pkg::usn_vec_t vec2_reg, vec3_reg, vec4_reg;
    usn_pkg::usn_vec_t vec2_next;
    logic [usn_pkg::SUM_W-1:0] sq_reg [3];
    logic [usn_pkg::SUM_W-1:0] sum_reg;

    // Valid bits move with the words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    // Differences and magnitudes of the cross product.
    always_comb
    begin
        c_next[0] = usn_pkg::CROSS_W'(p_reg[0]) - usn_pkg::CROSS_W'(p_reg[1]);
        c_next[1] = usn_pkg::CROSS_W'(p_reg[2]) - usn_pkg::CROSS_W'(p_reg[3]);
        c_next[2] = usn_pkg::CROSS_W'(p_reg[4]) - usn_pkg::CROSS_W'(p_reg[5]);
        for (int k = 0; k < 3; k++)
        begin
            vec2_next.neg[k] = c_next[k][usn_pkg::CROSS_W-1];
            vec2_next.mag[k] = c_next[k][usn_pkg::CROSS_W-1]
                             ? usn_pkg::MAG_W'(-c_next[k])
                             : usn_pkg::MAG_W'(c_next[k]);
        end
    end

    // Products, magnitudes, squares, sum.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= ay * bz;
            p_reg[1] <= az * by;
            p_reg[2] <= az * bx;
            p_reg[3] <= ax * bz;
            p_reg[4] <= ax * by;
            p_reg[5] <= ay * bx;
            vec2_reg <= vec2_next;
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k] <= usn_pkg::SUM_W'(vec2_reg.mag[k]) *
                             usn_pkg::SUM_W'(vec2_reg.mag[k]);
            end
            vec3_reg <= vec2_reg;
            sum_reg  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            vec4_reg <= vec3_reg;
        end
    end

    assign out_valid = vld_reg[3];
    assign vec       = vec4_reg;
    assign sum       = sum_reg;

endmodule

// File: hdl/usn_sqrt.sv
// ----------------------------------------------------------------------------
// usn_sqrt
// Floored square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module usn_sqrt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [usn_pkg::SUM_W-1:0]    sum,
    input  usn_pkg::usn_vec_t            in_vec,
    output logic                         out_valid,
    output logic [usn_pkg::ROOT_W-1:0]   root,
    output usn_pkg::usn_vec_t            out_vec
);

    localparam int N = usn_pkg::ROOT_W;

    logic [N-1:0]                  vld_reg;
    logic [usn_pkg::REM_W-1:0]     rem_reg  [N];
    logic [usn_pkg::ROOT_W-1:0]    root_reg [N];
    logic [usn_pkg::SUM_W-1:0]     x_reg    [N];
    usn_pkg::usn_vec_t             vec_reg  [N];

    // Valid bits move with the words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic [usn_pkg::REM_W-1:0]  rem_p, rem_sh, trial;
        logic [usn_pkg::ROOT_W-1:0] root_p;
        logic [usn_pkg::SUM_W-1:0]  x_p;
        usn_pkg::usn_vec_t          vec_p;
        logic                       ge;

        if (i == 0)
        begin : g_first
            assign rem_p  = '0;
            assign root_p = '0;
            assign x_p    = sum;
            assign vec_p  = in_vec;
        end
        else
        begin : g_next
            assign rem_p  = rem_reg[i-1];
            assign root_p = root_reg[i-1];
            assign x_p    = x_reg[i-1];
            assign vec_p  = vec_reg[i-1];
        end

        // Bring down two radicand bits and try the next root bit.
        assign rem_sh = {rem_p[usn_pkg::REM_W-3:0], x_p[usn_pkg::SUM_W-1 -: 2]};
        assign trial  = {root_p, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[i] <= {root_p[usn_pkg::ROOT_W-2:0], ge};
                x_reg[i]    <= {x_p[usn_pkg::SUM_W-3:0], 2'b00};
                vec_reg[i]  <= vec_p;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = root_reg[N-1];
    assign out_vec   = vec_reg[N-1];

endmodule

// File: hdl/usn_div.sv
// ----------------------------------------------------------------------------
// usn_div
// Three restoring dividers side by side, one quotient bit per stage.
// ----------------------------------------------------------------------------
module usn_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [usn_pkg::ROOT_W-1:0]        len,
    input  usn_pkg::usn_vec_t                 vec,
    output logic                              out_valid,
    output logic [usn_pkg::ROOT_W-1:0]        out_len,
    output logic [2:0]                        out_neg,
    output logic [2:0][usn_pkg::QUO_W-1:0]    quo
);

    localparam int N = usn_pkg::QUO_W;

    logic [N-1:0]                         vld_reg;
    logic [2:0][usn_pkg::DIV_W-1:0]       r_reg   [N];
    logic [2:0][usn_pkg::QUO_W-1:0]       q_reg   [N];
    logic [usn_pkg::ROOT_W-1:0]           len_reg [N];
    logic [2:0]                           neg_reg [N];

    // Valid bits move with the words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic [2:0][usn_pkg::DIV_W-1:0] r_p, r_sh, r_n;
        logic [2:0][usn_pkg::QUO_W-1:0] q_p, q_n;
        logic [usn_pkg::ROOT_W-1:0]     len_p;
        logic [2:0]                     neg_p;

        if (i == 0)
        begin : g_first
            for (genvar k = 0; k < 3; k++)
            begin : g_lane
                assign r_p[k] = {1'b0, vec.mag[k]};
            end
            assign q_p   = '0;
            assign len_p = len;
            assign neg_p = vec.neg;
        end
        else
        begin : g_next
            assign r_p   = r_reg[i-1];
            assign q_p   = q_reg[i-1];
            assign len_p = len_reg[i-1];
            assign neg_p = neg_reg[i-1];
        end

        // The integer bit needs no shift; each fraction bit shifts first.
        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                r_sh[k] = (i == 0) ? r_p[k] : {r_p[k][usn_pkg::DIV_W-2:0], 1'b0};
                if (r_sh[k] >= {1'b0, len_p})
                begin
                    r_n[k] = r_sh[k] - {1'b0, len_p};
                    q_n[k] = {q_p[k][usn_pkg::QUO_W-2:0], 1'b1};
                end
                else
                begin
                    r_n[k] = r_sh[k];
                    q_n[k] = {q_p[k][usn_pkg::QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i]   <= r_n;
                q_reg[i]   <= q_n;
                len_reg[i] <= len_p;
                neg_reg[i] <= neg_p;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_len   = len_reg[N-1];
    assign out_neg   = neg_reg[N-1];
    assign quo       = q_reg[N-1];

endmodule

// File: hdl/unit_surface_normal_core.sv
// Pipeline: 4 cross product stages, 32 square root stages, 15 divider stages and
// 1 output register between input word and output word; the depth is set by the
// one-bit-per-stage square root and dividers.
// Throughput: one word per cycle; a stall on the output freezes the whole pipeline.
// Reset: rst_n clears all valid bits asynchronously; data registers are not reset.
// ----------------------------------------------------------------------------
// unit_surface_normal_core
// Normalized cross product of two integer vectors as Q1.14 with its length.
// ----------------------------------------------------------------------------
module unit_surface_normal_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // ax, ay, az, bx, by, bz (16 bits each)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // nx, ny, nz (16 bits each), magnitude (32)
    output logic        m_tuser    // degenerate
);

    localparam int CW = usn_pkg::COORD_WIDTH;

    logic en;
    logic signed [CW-1:0] ax, ay, az, bx, by, bz;

    logic                                 cr_valid;
    usn_pkg::usn_vec_t                    cr_vec;
    logic [usn_pkg::SUM_W-1:0]            cr_sum;
    logic                                 sq_valid;
    logic [usn_pkg::ROOT_W-1:0]           sq_root;
    usn_pkg::usn_vec_t                    sq_vec;
    logic                                 dv_valid;
    logic [usn_pkg::ROOT_W-1:0]           dv_len;
    logic [2:0]                           dv_neg;
    logic [2:0][usn_pkg::QUO_W-1:0]       dv_quo;

    logic                                 out_valid_reg;
    logic [79:0]                          out_data_reg, out_data_next;
    logic                                 out_degen_reg, out_degen_next;

    // The pipeline advances whenever the output register can be loaded.
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    assign ax = s_tdata[0*16 +: CW];
    assign ay = s_tdata[1*16 +: CW];
    assign az = s_tdata[2*16 +: CW];
    assign bx = s_tdata[3*16 +: CW];
    assign by = s_tdata[4*16 +: CW];
    assign bz = s_tdata[5*16 +: CW];

    usn_cross u_cross
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .ax        (ax),
        .ay        (ay),
        .az        (az),
        .bx        (bx),
        .by        (by),
        .bz        (bz),
        .out_valid (cr_valid),
        .vec       (cr_vec),
        .sum       (cr_sum)
    );

    usn_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cr_valid),
        .sum       (cr_sum),
        .in_vec    (cr_vec),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_vec   (sq_vec)
    );

    usn_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .len       (sq_root),
        .vec       (sq_vec),
        .out_valid (dv_valid),
        .out_len   (dv_len),
        .out_neg   (dv_neg),
        .quo       (dv_quo)
    );

    // Apply signs, zero the normal of a degenerate word, pack the output.
    always_comb
    begin
        logic [usn_pkg::NORM_W-1:0] n;
        n = '0;
        out_degen_next = (dv_len == '0);
        for (int k = 0; k < 3; k++)
        begin
            n = usn_pkg::NORM_W'(dv_quo[k]);
            if (dv_neg[k])
            begin
                n = -n;
            end
            if (out_degen_next)
            begin
                n = '0;
            end
            out_data_next[k*16 +: 16] = n;
        end
        out_data_next[79:48] = usn_pkg::LEN_W'(dv_len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg  <= out_data_next;
            out_degen_reg <= out_degen_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_degen_reg;

`ifndef NO_ASSERTIONS
    // A degenerate word carries a zero normal and zero length.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("degenerate word has nonzero fields");

    // A nondegenerate word has a nonzero length.
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[79:48] != '0)
        else $error("zero length without degenerate flag");

    // The input side is held back only by a waiting output word.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output state");
`endif

endmodule
